// ===== hw/rtl/fbbcd_pkg.sv =====
package fbbcd_pkg;

   // Field widths of the request and response channels.
   localparam int ACT_W    = 2;
   localparam int FACE_W   = 16;
   localparam int SIZE_W   = 29;
   localparam int GLYPH_W  = 16;
   localparam int SUB_W    = 2;
   localparam int HINT_W   = 2;
   localparam int BYTES_W  = 19;
   localparam int SLOT_W   = 8;
   localparam int EVICT_W  = 9;
   localparam int USE_W    = 27;
   localparam int CNT_W    = 32;
   localparam int BUDGET_W = 27;

   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 27'd4194304;

   // Request action codes.
   localparam logic [ACT_W-1:0] ACT_ACQUIRE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_TRIM    = 2'd2;

   typedef struct packed {
      logic [FACE_W-1:0]  face;
      logic [SIZE_W-1:0]  size;
      logic [GLYPH_W-1:0] glyph;
      logic [SUB_W-1:0]   sub;
      logic [HINT_W-1:0]  hint;
   } key_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CLEAR,
      ST_EVQ,
      ST_EVA,
      ST_INSERT,
      ST_TRIM_CHK,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MODE_FULL,
      MODE_TRIM,
      MODE_CFG
   } mode_type;

   typedef struct packed {
      logic req_ready;
      logic scan;
      logic take_hit;
      logic take_miss;
      logic insert;
      logic ev_apply;
      logic clear;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic             req_fire;
      logic [ACT_W-1:0] act;
      logic             size_ok;
      logic             match;
      logic             scan_end;
      logic             full;
      logic             need_trim;
      logic             rsp_free;
   } status_type;

endpackage

// ===== hw/rtl/fbbcd_req_if.sv =====
interface fbbcd_req_if;
   logic                             valid;
   logic                             ready;
   logic [fbbcd_pkg::ACT_W-1:0]      action;
   logic [fbbcd_pkg::FACE_W-1:0]     face_id;
   logic [fbbcd_pkg::SIZE_W-1:0]     size_q16;
   logic                             size_ok;
   logic [fbbcd_pkg::GLYPH_W-1:0]    glyph_id;
   logic [fbbcd_pkg::SUB_W-1:0]      subpixel_step;
   logic [fbbcd_pkg::HINT_W-1:0]     hinting_mode;
   logic [fbbcd_pkg::BYTES_W-1:0]    entry_bytes;

   modport source (output valid, action, face_id, size_q16, size_ok, glyph_id,
                   subpixel_step, hinting_mode, entry_bytes, input ready);
   modport sink (input valid, action, face_id, size_q16, size_ok, glyph_id,
                 subpixel_step, hinting_mode, entry_bytes, output ready);
endinterface

// ===== hw/rtl/fbbcd_rsp_if.sv =====
interface fbbcd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             rejected;
   logic                             hit;
   logic                             usable;
   logic [fbbcd_pkg::SLOT_W-1:0]     slot;
   logic [fbbcd_pkg::EVICT_W-1:0]    evicted_now;
   logic [fbbcd_pkg::USE_W-1:0]      bytes_in_use;
   logic [fbbcd_pkg::CNT_W-1:0]      hit_count;
   logic [fbbcd_pkg::CNT_W-1:0]      miss_count;

   modport source (output valid, rejected, hit, usable, slot, evicted_now, bytes_in_use,
                   hit_count, miss_count, input ready);
   modport sink (input valid, rejected, hit, usable, slot, evicted_now, bytes_in_use,
                 hit_count, miss_count, output ready);
endinterface

// ===== hw/rtl/fifo_byte_budget_cache_directory_core.sv =====
// Directory of a glyph cache with a byte budget and insertion-order eviction.
// Requests arrive on req_ch (valid/ready): an acquire with a glyph key and the
// byte size of a new entry, a clear, or a trim to the budget. Each request gives
// exactly one response on rsp_ch (valid/ready), in request order.
// The user must write the budget register through csr_wr_en/csr_wr_data only
// while the block is idle; the block does not enforce this. A write trims the
// directory to the new budget before the next request is taken, and those
// evictions are reported nowhere. An acquire scans the key table one entry per
// cycle after a read setup step and stops at a hit; a miss scans every entry,
// then inserts the new entry and checks the budget. A miss on a full table
// first drops the oldest entry, and each entry evicted to meet the budget takes
// a budget check, an age queue read and an update. A rejected or unused request
// goes straight to its response, a clear passes through a clearing state, and
// a trim runs a budget check plus any evictions. One request is worked on at a
// time; the key table scan sets the throughput. The response register lets the
// next request be accepted while a response waits; when the receiver stalls,
// finished work holds until the response register frees up.
// Reset (synchronous, active high) empties the directory, zeroes the byte total
// and counters and restores the default budget; there is no clearing pass.
module fifo_byte_budget_cache_directory_core #(
   parameter int ENTRIES        = 256,
   parameter int SUBPIXEL_STEPS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [fbbcd_pkg::BUDGET_W-1:0] csr_wr_data,
   fbbcd_req_if.sink                      req_ch,
   fbbcd_rsp_if.source                    rsp_ch
);

   // Commands flow from the controller to the datapath, status flows back.
   fbbcd_pkg::cmd_type    cmd;
   fbbcd_pkg::status_type st;

   fbbcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .st        (st),
      .cmd       (cmd)
   );

   fbbcd_dpath #(
      .ENTRIES        (ENTRIES),
      .SUBPIXEL_STEPS (SUBPIXEL_STEPS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .cmd         (cmd),
      .st          (st)
   );

`ifndef NO_ASSERTIONS
   // A response is only loaded when the response register can take it.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> st.rsp_free) else $error("response loaded while occupied");

   // An insert always finds a free table slot.
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !st.full) else $error("insert into a full table");

   // A scan ends in either a hit or a miss, never both.
   a_hit_miss: assert property (@(posedge clock) disable iff (reset)
      !(cmd.take_hit && cmd.take_miss)) else $error("hit and miss together");

   // No request is taken the cycle after a budget write; the trim runs first.
   a_cfg_block: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_ch.ready) else $error("request taken during budget trim");
`endif

endmodule

// ===== hw/rtl/fbbcd_ctrl.sv =====
module fbbcd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  fbbcd_pkg::status_type st,
   output fbbcd_pkg::cmd_type    cmd
);

   fbbcd_pkg::state_type state_ff, state_in;
   fbbcd_pkg::mode_type  mode_ff, mode_in;
   logic                 cfg_pend_ff, cfg_pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= fbbcd_pkg::ST_IDLE;
         mode_ff     <= fbbcd_pkg::MODE_TRIM;
         cfg_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         cfg_pend_ff <= cfg_pend_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      cfg_pend_in = cfg_pend_ff | csr_wr_en;
      unique case (state_ff)
         fbbcd_pkg::ST_IDLE: begin
            if (cfg_pend_ff) begin
               state_in    = fbbcd_pkg::ST_TRIM_CHK;
               mode_in     = fbbcd_pkg::MODE_CFG;
               cfg_pend_in = csr_wr_en;
            end else if (st.req_fire) begin
               mode_in = fbbcd_pkg::MODE_TRIM;
               unique case (st.act)
                  fbbcd_pkg::ACT_ACQUIRE:
                     state_in = st.size_ok ? fbbcd_pkg::ST_SCAN : fbbcd_pkg::ST_FINISH;
                  fbbcd_pkg::ACT_CLEAR: state_in = fbbcd_pkg::ST_CLEAR;
                  fbbcd_pkg::ACT_TRIM:  state_in = fbbcd_pkg::ST_TRIM_CHK;
                  default:              state_in = fbbcd_pkg::ST_FINISH;
               endcase
            end
         end
         fbbcd_pkg::ST_SCAN: begin
            if (st.match) begin
               state_in = fbbcd_pkg::ST_FINISH;
            end else if (st.scan_end) begin
               if (st.full) begin
                  state_in = fbbcd_pkg::ST_EVQ;
                  mode_in  = fbbcd_pkg::MODE_FULL;
               end else begin
                  state_in = fbbcd_pkg::ST_INSERT;
               end
            end
         end
         fbbcd_pkg::ST_CLEAR: state_in = fbbcd_pkg::ST_FINISH;
         fbbcd_pkg::ST_EVQ:   state_in = fbbcd_pkg::ST_EVA;
         fbbcd_pkg::ST_EVA: begin
            state_in = (mode_ff == fbbcd_pkg::MODE_FULL) ? fbbcd_pkg::ST_INSERT
                                                         : fbbcd_pkg::ST_TRIM_CHK;
         end
         fbbcd_pkg::ST_INSERT: begin
            mode_in  = fbbcd_pkg::MODE_TRIM;
            state_in = fbbcd_pkg::ST_TRIM_CHK;
         end
         fbbcd_pkg::ST_TRIM_CHK: begin
            if (st.need_trim) begin
               state_in = fbbcd_pkg::ST_EVQ;
            end else if (mode_ff == fbbcd_pkg::MODE_CFG) begin
               state_in = fbbcd_pkg::ST_IDLE;
            end else begin
               state_in = fbbcd_pkg::ST_FINISH;
            end
         end
         fbbcd_pkg::ST_FINISH: begin
            if (st.rsp_free) begin
               state_in = fbbcd_pkg::ST_IDLE;
            end
         end
         default: state_in = fbbcd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.req_ready = (state_ff == fbbcd_pkg::ST_IDLE) && !cfg_pend_ff && !csr_wr_en;
      cmd.scan      = (state_ff == fbbcd_pkg::ST_SCAN);
      cmd.take_hit  = (state_ff == fbbcd_pkg::ST_SCAN) && st.match;
      cmd.take_miss = (state_ff == fbbcd_pkg::ST_SCAN) && !st.match && st.scan_end;
      cmd.insert    = (state_ff == fbbcd_pkg::ST_INSERT);
      cmd.ev_apply  = (state_ff == fbbcd_pkg::ST_EVA);
      cmd.clear     = (state_ff == fbbcd_pkg::ST_CLEAR);
      cmd.load_rsp  = (state_ff == fbbcd_pkg::ST_FINISH) && st.rsp_free;
   end

endmodule

// ===== hw/rtl/fbbcd_dpath.sv =====
module fbbcd_dpath #(
   parameter int ENTRIES        = 256,
   parameter int SUBPIXEL_STEPS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [fbbcd_pkg::BUDGET_W-1:0]      csr_wr_data,
   fbbcd_req_if.sink                           req,
   fbbcd_rsp_if.source                         rsp,
   input  fbbcd_pkg::cmd_type                  cmd,
   output fbbcd_pkg::status_type               st
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = IW + 1;
   localparam int UW = (IW + fbbcd_pkg::BYTES_W > fbbcd_pkg::USE_W) ?
                       IW + fbbcd_pkg::BYTES_W : fbbcd_pkg::USE_W;
   localparam logic [CW-1:0] ENT_C    = CW'(ENTRIES);
   localparam logic [CW:0]   ENT_W    = (CW + 1)'(ENTRIES);
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
   localparam logic [UW-1:0] USE_MAX  = UW'({fbbcd_pkg::USE_W{1'b1}});

   typedef struct packed {
      fbbcd_pkg::key_type              key;
      logic [fbbcd_pkg::BYTES_W-1:0]   bytes;
   } dent_type;

   typedef struct packed {
      logic [IW-1:0]                   slot;
      logic [fbbcd_pkg::BYTES_W-1:0]   bytes;
   } qent_type;

   dent_type dir_mem [ENTRIES];
   qent_type age_mem [ENTRIES];
   dent_type dir_rd_ff;
   qent_type age_rd_ff;

   logic [ENTRIES-1:0]                 valid_ff, valid_in;
   logic [fbbcd_pkg::BUDGET_W-1:0]     budget_ff;
   logic [CW-1:0]                      scan_addr_ff;
   logic [IW-1:0]                      cmp_idx_ff;
   logic                               cmp_valid_ff;
   logic                               free_found_ff;
   logic [IW-1:0]                      free_slot_ff;
   logic [IW-1:0]                      head_ff;
   logic [CW-1:0]                      count_ff;
   logic [UW-1:0]                      used_ff;
   logic [fbbcd_pkg::CNT_W-1:0]        hits_ff, misses_ff;
   logic [fbbcd_pkg::EVICT_W-1:0]      evict_ff;
   logic [IW-1:0]                      last_ev_ff;
   logic                               rsp_valid_ff;

   fbbcd_pkg::key_type                 key_ff, req_key;
   logic [fbbcd_pkg::BYTES_W-1:0]      bytes_ff;
   logic                               rej_ff, hit_ff, miss_ff, hit_usable_ff;
   logic [IW-1:0]                      slot_ff;

   logic                               rsp_rej_ff, rsp_hit_ff, rsp_usable_ff;
   logic [fbbcd_pkg::SLOT_W-1:0]       rsp_slot_ff;
   logic [fbbcd_pkg::EVICT_W-1:0]      rsp_evict_ff;
   logic [fbbcd_pkg::USE_W-1:0]        rsp_bytes_ff;
   logic [fbbcd_pkg::CNT_W-1:0]        rsp_hits_ff, rsp_misses_ff;

   logic                               req_fire, rsp_fire, match, fin_usable;
   logic [IW-1:0]                      ins_slot, tail_idx;
   logic [CW:0]                        tail_sum;
   logic [UW-1:0]                      ev_sub;

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign req.ready = cmd.req_ready;

   always_comb begin
      req_key.face  = req.face_id;
      req_key.size  = req.size_q16;
      req_key.glyph = req.glyph_id;
      req_key.sub   = (int'(req.subpixel_step) > SUBPIXEL_STEPS - 1) ?
                      fbbcd_pkg::SUB_W'(SUBPIXEL_STEPS - 1) : req.subpixel_step;
      req_key.hint  = req.hinting_mode;
   end

   assign match    = cmp_valid_ff && valid_ff[cmp_idx_ff] && (dir_rd_ff.key == key_ff);
   assign ins_slot = free_found_ff ? free_slot_ff : last_ev_ff;
   assign tail_sum = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign tail_idx = (tail_sum >= ENT_W) ? IW'(tail_sum - ENT_W) : IW'(tail_sum);
   assign ev_sub   = (UW'(age_rd_ff.bytes) < used_ff) ? UW'(age_rd_ff.bytes) : used_ff;
   assign fin_usable = hit_ff ? hit_usable_ff :
                       (miss_ff && valid_ff[slot_ff] && (bytes_ff != '0));

   always_comb begin
      st           = '0;
      st.req_fire  = req_fire;
      st.act       = req.action;
      st.size_ok   = req.size_ok;
      st.match     = match;
      st.scan_end  = cmp_valid_ff && (cmp_idx_ff == LAST_IDX);
      st.full      = (count_ff == ENT_C);
      st.need_trim = (used_ff > UW'(budget_ff)) && (count_ff != '0);
      st.rsp_free  = !rsp_valid_ff || rsp.ready;
   end

   // Key table and age queue, one write and one registered read each.
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         dir_mem[ins_slot] <= dent_type'{key: key_ff, bytes: bytes_ff};
      end
      if (scan_addr_ff < ENT_C) begin
         dir_rd_ff <= dir_mem[scan_addr_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         age_mem[tail_idx] <= qent_type'{slot: ins_slot, bytes: bytes_ff};
      end
      age_rd_ff <= age_mem[head_ff];
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (cmd.insert) begin
         valid_in[ins_slot] = 1'b1;
      end else if (cmd.ev_apply) begin
         valid_in[age_rd_ff.slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         budget_ff     <= fbbcd_pkg::BUDGET_RESET;
         scan_addr_ff  <= '0;
         cmp_valid_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         head_ff       <= '0;
         count_ff      <= '0;
         used_ff       <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         evict_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (csr_wr_en) begin
            budget_ff <= csr_wr_data;
         end
         if (req_fire) begin
            scan_addr_ff  <= '0;
            cmp_valid_ff  <= 1'b0;
            free_found_ff <= 1'b0;
            evict_ff      <= '0;
         end else if (cmd.scan) begin
            if (scan_addr_ff < ENT_C) begin
               scan_addr_ff <= scan_addr_ff + 1'b1;
               cmp_valid_ff <= 1'b1;
            end else begin
               cmp_valid_ff <= 1'b0;
            end
            if (cmp_valid_ff && !valid_ff[cmp_idx_ff] && !free_found_ff) begin
               free_found_ff <= 1'b1;
            end
         end
         if (cmd.take_hit && (hits_ff != '1)) begin
            hits_ff <= hits_ff + 1'b1;
         end
         if (cmd.take_miss && (misses_ff != '1)) begin
            misses_ff <= misses_ff + 1'b1;
         end
         if (cmd.clear) begin
            head_ff  <= '0;
            count_ff <= '0;
            used_ff  <= '0;
         end else if (cmd.insert) begin
            count_ff <= count_ff + 1'b1;
            used_ff  <= used_ff + UW'(bytes_ff);
         end else if (cmd.ev_apply) begin
            head_ff  <= (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
            count_ff <= count_ff - 1'b1;
            used_ff  <= used_ff - ev_sub;
            if (evict_ff != '1) begin
               evict_ff <= evict_ff + 1'b1;
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         key_ff   <= req_key;
         bytes_ff <= req.entry_bytes;
         rej_ff   <= (req.action == fbbcd_pkg::ACT_ACQUIRE) && !req.size_ok;
         hit_ff   <= 1'b0;
         miss_ff  <= 1'b0;
      end
      if (cmd.scan && (scan_addr_ff < ENT_C)) begin
         cmp_idx_ff <= scan_addr_ff[IW-1:0];
      end
      if (cmd.scan && cmp_valid_ff && !valid_ff[cmp_idx_ff] && !free_found_ff) begin
         free_slot_ff <= cmp_idx_ff;
      end
      if (cmd.take_hit) begin
         hit_ff        <= 1'b1;
         slot_ff       <= cmp_idx_ff;
         hit_usable_ff <= (dir_rd_ff.bytes != '0);
      end
      if (cmd.take_miss) begin
         miss_ff <= 1'b1;
      end
      if (cmd.insert) begin
         slot_ff <= ins_slot;
      end
      if (cmd.ev_apply) begin
         last_ev_ff <= age_rd_ff.slot;
      end
      if (cmd.load_rsp) begin
         rsp_rej_ff    <= rej_ff;
         rsp_hit_ff    <= hit_ff;
         rsp_usable_ff <= fin_usable;
         rsp_slot_ff   <= fin_usable ? fbbcd_pkg::SLOT_W'(slot_ff) : '0;
         rsp_evict_ff  <= evict_ff;
         rsp_bytes_ff  <= (used_ff > USE_MAX) ? '1 : fbbcd_pkg::USE_W'(used_ff);
         rsp_hits_ff   <= hits_ff;
         rsp_misses_ff <= misses_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.rejected     = rsp_rej_ff;
   assign rsp.hit          = rsp_hit_ff;
   assign rsp.usable       = rsp_usable_ff;
   assign rsp.slot         = rsp_slot_ff;
   assign rsp.evicted_now  = rsp_evict_ff;
   assign rsp.bytes_in_use = rsp_bytes_ff;
   assign rsp.hit_count    = rsp_hits_ff;
   assign rsp.miss_count   = rsp_misses_ff;

endmodule
